### hdl/hdlcd_pkg.sv
// ----------------------------------------------------------------------------
// hdlcd_pkg
// Shared types, codes and the CRC-16 byte update for the HDLC deframer.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

  // Frame limit default
  localparam int MAX_FRAME_DEF = 256;

  // Line control bytes
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_START = 16'hFFFF;

  // Configuration registers
  localparam int          MAX_LEN_W     = 9;
  localparam int          CFG_DATA_W    = 16;
  localparam logic [0:0]  REG_MAX_LEN   = 1'b0;
  localparam logic [0:0]  REG_CRC_POLY  = 1'b1;
  localparam logic [8:0]  MAX_LEN_RST   = 9'd256;
  localparam logic [15:0] CRC_POLY_RST  = 16'h1021;

  // Receive phases
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // Result events
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_BYTE = 3'd1;
  localparam logic [2:0] EV_GOOD = 3'd2;
  localparam logic [2:0] EV_BAD  = 3'd3;
  localparam logic [2:0] EV_OVER = 3'd4;

  // One received line byte
  typedef struct packed {
    logic       restart;
    logic [7:0] rx_byte;
  } rx_item_t;

  // One result
  typedef struct packed {
    logic       in_frame;
    logic [8:0] frame_length;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic [2:0] event_res;
  } rx_result_t;

  // MSB-first CRC-16 update by one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                           input logic [7:0]  b,
                                           input logic [15:0] poly);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (x[15]) begin
        x = {x[14:0], 1'b0} ^ poly;
      end else begin
        x = {x[14:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

### hdl/hdlcd_in_stage.sv
// ----------------------------------------------------------------------------
// hdlcd_in_stage
// Input register: holds one received request until the core takes it.
// ----------------------------------------------------------------------------
module hdlcd_in_stage
  import hdlcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rx_item_t in_item,
  output logic     item_valid,
  output rx_item_t item,
  input  logic     item_take
);

  logic     vld_r, vld_nxt;
  rx_item_t item_r;

  // Accept when empty or when the held request moves on this cycle
  assign in_ready = !vld_r || item_take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

### hdl/hdlcd_core.sv
// ----------------------------------------------------------------------------
// hdlcd_core
// Deframer state, unstuffing, CRC check, config registers and result register.
// ----------------------------------------------------------------------------
module hdlcd_core
  import hdlcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  item_valid,
  input  rx_item_t              item,
  output logic                  item_take,
  output logic                  res_valid,
  output rx_result_t            res,
  input  logic                  res_ready
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int CMP_W = (CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W;

  logic [MAX_LEN_W-1:0] max_len_r;
  logic [15:0]          poly_r;
  logic [1:0]           phase_r, phase_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_vld_r, out_vld_nxt;
  rx_result_t           res_r, res_nxt;

  logic [1:0]           phase_cur;
  logic [CMP_W-1:0]     lim;
  logic [CMP_W-1:0]     cnt_ext;
  logic                 take_data;
  logic [7:0]           take_byte;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      poly_r    <= CRC_POLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LEN:  max_len_r <= cfg_wdata[MAX_LEN_W-1:0];
        REG_CRC_POLY: poly_r    <= cfg_wdata[15:0];
        default:      ;
      endcase
    end
  end

  // Advance when the result register is free or being drained
  assign item_take = item_valid && (!out_vld_r || res_ready);

  // Effective length limit
  assign cnt_ext = CMP_W'(cnt_r);
  always_comb begin
    if (CMP_W'(max_len_r) > CMP_W'(MAX_FRAME)) begin
      lim = CMP_W'(MAX_FRAME);
    end else begin
      lim = CMP_W'(max_len_r);
    end
  end

  // Phase decode and byte classification
  always_comb begin
    phase_cur = item.restart ? PH_HUNT : phase_r;
    phase_nxt = phase_cur;
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    take_data = 1'b0;
    take_byte = item.rx_byte;
    res_nxt   = '0;
    res_nxt.event_res = EV_NONE;

    case (phase_cur)
      PH_ESC: begin
        take_data = 1'b1;
        take_byte = item.rx_byte ^ ESC_XOR;
      end
      PH_DATA: begin
        if (item.rx_byte == FLAG_BYTE) begin
          phase_nxt = PH_HUNT;
          if (crc_r == 16'h0000) begin
            res_nxt.event_res    = EV_GOOD;
            res_nxt.frame_length = cnt_ext[8:0];
          end else begin
            res_nxt.event_res = EV_BAD;
          end
        end else if (item.rx_byte == ESC_BYTE) begin
          phase_nxt = PH_ESC;
        end else begin
          take_data = 1'b1;
        end
      end
      default: begin
        // Hunt for an opening flag; unused code behaves the same
        phase_nxt = PH_HUNT;
        if (item.rx_byte == FLAG_BYTE) begin
          cnt_nxt   = '0;
          crc_nxt   = CRC_START;
          phase_nxt = PH_DATA;
        end
      end
    endcase

    // Store one data byte, or abort on overflow
    if (take_data) begin
      if (cnt_ext >= lim) begin
        phase_nxt         = PH_HUNT;
        res_nxt.event_res = EV_OVER;
      end else begin
        res_nxt.event_res  = EV_BYTE;
        res_nxt.data_byte  = take_byte;
        res_nxt.byte_index = cnt_ext[7:0];
        cnt_nxt            = cnt_r + 1'b1;
        crc_nxt            = crc_step(crc_r, take_byte, poly_r);
        phase_nxt          = PH_DATA;
      end
    end

    res_nxt.in_frame = (phase_nxt != PH_HUNT);
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      crc_r   <= CRC_START;
      cnt_r   <= '0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register
  assign out_vld_nxt = item_take ? 1'b1 : (out_vld_r && !res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = out_vld_r;
  assign res       = res_r;

endmodule

### hdl/hdlc_byte_stuff_deframer.sv
// ----------------------------------------------------------------------------
// hdlc_byte_stuff_deframer
// HDLC byte-stuffed deframer with CRC-16 frame check, one line byte per request.
// ----------------------------------------------------------------------------
//   channel | direction | tdata                          | tuser
//   in_     | slave     | rx_byte                        | restart
//   out_    | master    | data_byte, byte_index, length  | event_res, in_frame
//   cfg_    | write     | max_length / crc_poly          | -
//
// One request per clock while the output is not stalled: an input register feeds
// the unstuff/CRC logic, whose combinational byte-wide CRC update writes the result
// register, so each byte passes through both registers from accept to result.
// Synchronous active-low reset puts the deframer in flag hunt with CRC 0xFFFF.
// A stalled output holds the result; the input keeps one request buffered.
// ----------------------------------------------------------------------------
module hdlc_byte_stuff_deframer
  import hdlcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] restart
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [7:0] data_byte, [15:8] byte_index,
                                            // [24:16] frame_length, [31:25] zero
  output logic [3:0]            out_tuser   // [2:0] event_res, [3] in_frame
);

  rx_item_t   in_item;
  rx_item_t   item;
  logic       item_valid;
  logic       item_take;
  rx_result_t res;

  assign in_item.rx_byte = in_tdata;
  assign in_item.restart = in_tuser;

  hdlcd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  hdlcd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  // Pack result fields
  assign out_tdata = {7'd0, res.frame_length, res.byte_index, res.data_byte};
  assign out_tuser = {res.in_frame, res.event_res};

endmodule
